FILE: hw/rtl/acr_pkg.sv
// acr_pkg: types, codes and constants shared by the ARP cache responder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package acr_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 16;
  localparam int unsigned PENDING_SLOTS_DEF = 8;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned IN_DATA_W  = 240;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd1;

  localparam logic [15:0] PT_IPV4    = 16'h0800;
  localparam logic [15:0] PT_INVALID = 16'hFFFF;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;
  localparam logic [15:0] OP_MAX     = 16'd25;
  localparam logic [15:0] HW_ETH     = 16'd1;
  localparam logic [15:0] HW_GAP_LO  = 16'd39;
  localparam logic [15:0] HW_GAP_HI  = 16'd255;
  localparam logic [15:0] HW_TOP     = 16'd258;

  typedef enum logic [3:0] {
    ST_BAD_OPCODE   = 4'd0,
    ST_BAD_HWTYPE   = 4'd1,
    ST_BAD_PROTO    = 4'd2,
    ST_SHORT        = 4'd3,
    ST_NON_ETH      = 4'd4,
    ST_NON_IPV4_REQ = 4'd5,
    ST_REPLY_OTHER  = 4'd6,
    ST_LEARNED      = 4'd7,
    ST_REPLY_NEEDED = 4'd8,
    ST_REQ_OTHER    = 4'd9,
    ST_HIT          = 4'd10,
    ST_QUEUED       = 4'd11,
    ST_QUEUE_FULL   = 4'd12,
    ST_RELEASED     = 4'd13
  } status_e;

  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_LEARN  = 2'd1,
    K_LOOKUP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [SLOT_W-1:0]  slot;
    logic               req;
    logic               full;
  } res_t;

endpackage

FILE: hw/rtl/acr_front.sv
// acr_front: accepts input items, holds the config registers and classifies
// each packet or lookup into a command for the back end. Uses acr_pkg.
`timescale 1ns / 1ps
module acr_front import acr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [MAC_W-1:0]      cfg_data_i,
  input  logic                  s_valid_i,
  input  logic                  s_op_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  output logic                  s_ready_o,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  logic                  q_ready_i
);

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_OWN_MAC) own_mac_q <= cfg_data_i;
      if (cfg_index_i == REG_OWN_IP)  own_ip_q  <= cfg_data_i[IP_W-1:0];
    end
  end

  logic [15:0]      op, hw, pt, len;
  logic [7:0]       hl, pl;
  logic [MAC_W-1:0] smac, tmac;
  logic [IP_W-1:0]  sip, tip;
  logic [10:0]      need_len;
  logic             emit;

  assign op   = s_data_i[15:0];
  assign hw   = s_data_i[31:16];
  assign pt   = s_data_i[47:32];
  assign hl   = s_data_i[55:48];
  assign pl   = s_data_i[63:56];
  assign len  = s_data_i[79:64];
  assign smac = s_data_i[127:80];
  assign sip  = s_data_i[159:128];
  assign tmac = s_data_i[207:160];
  assign tip  = s_data_i[239:208];
  assign need_len = 11'd8 + {2'b0, hl, 1'b0} + {2'b0, pl, 1'b0};

  always_comb begin
    emit        = 1'b1;
    cmd_o.kind   = K_SIMPLE;
    cmd_o.status = ST_BAD_OPCODE;
    cmd_o.mac    = '0;
    cmd_o.ip     = sip;
    if (s_op_i) begin
      cmd_o.kind = K_LOOKUP;
      cmd_o.ip   = tip;
    end else if (op < OP_REQUEST || op > OP_MAX) begin
      cmd_o.status = ST_BAD_OPCODE;
    end else if (hw < HW_ETH || (hw >= HW_GAP_LO && hw <= HW_GAP_HI) || hw >= HW_TOP) begin
      cmd_o.status = ST_BAD_HWTYPE;
    end else if (pt == PT_INVALID) begin
      cmd_o.status = ST_BAD_PROTO;
    end else if (len < {5'b0, need_len}) begin
      cmd_o.status = ST_SHORT;
    end else if (hw != HW_ETH) begin
      cmd_o.status = ST_NON_ETH;
    end else if (op == OP_REPLY) begin
      if (tmac != own_mac_q || pt != PT_IPV4) begin
        cmd_o.status = ST_REPLY_OTHER;
      end else begin
        cmd_o.kind = K_LEARN;
        cmd_o.mac  = smac;
      end
    end else if (op == OP_REQUEST) begin
      if (pt != PT_IPV4) begin
        cmd_o.status = ST_NON_IPV4_REQ;
      end else if (tip == own_ip_q) begin
        cmd_o.status = ST_REPLY_NEEDED;
        cmd_o.mac    = smac;
      end else begin
        cmd_o.status = ST_REQ_OTHER;
        cmd_o.ip     = tip;
      end
    end else begin
      // well-formed packet with an opcode we do not handle: no result
      emit = 1'b0;
    end
  end

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i && q_ready_i && emit;

endmodule

FILE: hw/rtl/acr_queue.sv
// acr_queue: two-entry command queue between front and back end.
// Uses acr_pkg for the command type.
`timescale 1ns / 1ps
module acr_queue import acr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rd_q];

endmodule

FILE: hw/rtl/acr_back.sv
// acr_back: carries out commands: cache scan, learning, pending slot scan,
// claim and release, and drives the result register. Uses acr_pkg.
`timescale 1ns / 1ps
module acr_back import acr_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_SLOTS = PENDING_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  output logic m_valid_o,
  output res_t m_res_o,
  output logic m_last_o,
  input  logic m_ready_i
);

  localparam int unsigned CW = $clog2(CACHE_ENTRIES);
  localparam int unsigned PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam logic [CW-1:0] C_LAST = CW'(CACHE_ENTRIES - 1);
  localparam logic [PW-1:0] P_LAST = PW'(PENDING_SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRD   = 3'd1;
  localparam logic [2:0] S_CCMP  = 3'd2;
  localparam logic [2:0] S_LWR   = 3'd3;
  localparam logic [2:0] S_PRD   = 3'd4;
  localparam logic [2:0] S_PCMP  = 3'd5;
  localparam logic [2:0] S_CLAIM = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [CW-1:0]       cidx_q, cidx_d, cfree_q, cfree_d;
  logic                known_q, known_d, cff_q, cff_d;
  logic [PW-1:0]       pidx_q, pidx_d, pfree_q, pfree_d;
  logic                pend_q, pend_d, pff_q, pff_d;
  res_t                hold_q, hold_d;
  logic                hold_v_q, hold_v_d;
  res_t                out_q, out_d;
  logic                out_v_q, out_v_d, out_last_q, out_last_d;
  logic [CACHE_ENTRIES-1:0] cvalid_q, cvalid_d;
  logic [PENDING_SLOTS-1:0] pvalid_q, pvalid_d;

  // cache and pending address stores, registered reads
  logic [IP_W-1:0]  cache_ip  [CACHE_ENTRIES];
  logic [MAC_W-1:0] cache_mac [CACHE_ENTRIES];
  logic [IP_W-1:0]  pend_ip   [PENDING_SLOTS];
  logic [IP_W-1:0]  rd_cip_q, rd_pip_q;
  logic [MAC_W-1:0] rd_cmac_q;
  logic             c_we, p_we;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cache_ip[cfree_q]  <= cmd_q.ip;
      cache_mac[cfree_q] <= cmd_q.mac;
    end
    rd_cip_q  <= cache_ip[cidx_q];
    rd_cmac_q <= cache_mac[cidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pend_ip[pfree_q] <= cmd_q.ip;
    rd_pip_q <= pend_ip[pidx_q];
  end

  logic             out_free, push;
  logic [IP_W-1:0]  c_ip;
  logic [MAC_W-1:0] c_mac;
  logic             c_hit, p_hit;

  // entry 0 is the broadcast binding, fixed from reset
  assign c_ip     = (cidx_q == '0) ? '1 : rd_cip_q;
  assign c_mac    = (cidx_q == '0) ? '1 : rd_cmac_q;
  assign c_hit    = cvalid_q[cidx_q] && (c_ip == cmd_q.ip);
  assign p_hit    = pvalid_q[pidx_q] && (rd_pip_q == cmd_q.ip);
  assign out_free = !out_v_q || m_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cidx_d     = cidx_q;
    cfree_d    = cfree_q;
    known_d    = known_q;
    cff_d      = cff_q;
    pidx_d     = pidx_q;
    pfree_d    = pfree_q;
    pend_d     = pend_q;
    pff_d      = pff_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    cvalid_d   = cvalid_q;
    pvalid_d   = pvalid_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    push       = 1'b0;
    pop_o      = 1'b0;
    c_we       = 1'b0;
    p_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = q_cmd_i;
          cidx_d  = '0;
          known_d = 1'b0;
          cff_d   = 1'b0;
          pend_d  = 1'b0;
          pff_d   = 1'b0;
          if (q_cmd_i.kind == K_SIMPLE) begin
            hold_d   = '{status: q_cmd_i.status, mac: q_cmd_i.mac, ip: q_cmd_i.ip,
                         slot: '0, req: 1'b0, full: 1'b0};
            hold_v_d = 1'b1;
            state_d  = S_FIN;
          end else begin
            state_d = S_CRD;
          end
        end
      end
      S_CRD: state_d = S_CCMP;
      S_CCMP: begin
        if (cmd_q.kind == K_LOOKUP && c_hit) begin
          hold_d   = '{status: ST_HIT, mac: c_mac, ip: cmd_q.ip,
                       slot: '0, req: 1'b0, full: 1'b0};
          hold_v_d = 1'b1;
          state_d  = S_FIN;
        end else begin
          if (c_hit) begin
            known_d = 1'b1;
          end else if (!cvalid_q[cidx_q] && !cff_q) begin
            cff_d   = 1'b1;
            cfree_d = cidx_q;
          end
          if (cidx_q == C_LAST) begin
            pidx_d  = '0;
            state_d = (cmd_q.kind == K_LEARN) ? S_LWR : S_PRD;
          end else begin
            cidx_d  = cidx_q + 1'b1;
            state_d = S_CRD;
          end
        end
      end
      S_LWR: begin
        if (!known_q && cff_q) begin
          c_we               = 1'b1;
          cvalid_d[cfree_q]  = 1'b1;
        end
        hold_d   = '{status: ST_LEARNED, mac: cmd_q.mac, ip: cmd_q.ip,
                     slot: '0, req: 1'b0, full: !known_q && !cff_q};
        hold_v_d = 1'b1;
        state_d  = S_PRD;
      end
      S_PRD: state_d = S_PCMP;
      S_PCMP: begin
        if (cmd_q.kind == K_LEARN && p_hit) begin
          // earlier result leaves now, so only the final one carries last
          if (out_free) begin
            push             = 1'b1;
            out_d            = hold_q;
            out_last_d       = 1'b0;
            pvalid_d[pidx_q] = 1'b0;
            hold_d   = '{status: ST_RELEASED, mac: cmd_q.mac, ip: cmd_q.ip,
                         slot: SLOT_W'(pidx_q), req: 1'b0, full: 1'b0};
          end
        end else if (cmd_q.kind == K_LOOKUP) begin
          if (p_hit) begin
            pend_d = 1'b1;
          end else if (!pvalid_q[pidx_q] && !pff_q) begin
            pff_d   = 1'b1;
            pfree_d = pidx_q;
          end
        end
        if (!(cmd_q.kind == K_LEARN && p_hit && !out_free)) begin
          if (pidx_q == P_LAST) begin
            state_d = (cmd_q.kind == K_LEARN) ? S_FIN : S_CLAIM;
          end else begin
            pidx_d  = pidx_q + 1'b1;
            state_d = S_PRD;
          end
        end
      end
      S_CLAIM: begin
        if (pff_q) begin
          p_we              = 1'b1;
          pvalid_d[pfree_q] = 1'b1;
          hold_d = '{status: ST_QUEUED, mac: '0, ip: cmd_q.ip,
                     slot: SLOT_W'(pfree_q), req: !pend_q, full: 1'b0};
        end else begin
          hold_d = '{status: ST_QUEUE_FULL, mac: '0, ip: cmd_q.ip,
                     slot: '0, req: 1'b0, full: 1'b0};
        end
        hold_v_d = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          push       = 1'b1;
          out_d      = hold_q;
          out_last_d = 1'b1;
          hold_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push)           out_v_d = 1'b1;
    else if (m_ready_i) out_v_d = 1'b0;
    else                out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cvalid_q <= {{(CACHE_ENTRIES-1){1'b0}}, 1'b1};
      pvalid_q <= '0;
      cidx_q   <= '0;
      pidx_q   <= '0;
      known_q  <= 1'b0;
      cff_q    <= 1'b0;
      pend_q   <= 1'b0;
      pff_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      cvalid_q <= cvalid_d;
      pvalid_q <= pvalid_d;
      cidx_q   <= cidx_d;
      pidx_q   <= pidx_d;
      known_q  <= known_d;
      cff_q    <= cff_d;
      pend_q   <= pend_d;
      pff_q    <= pff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cfree_q    <= cfree_d;
    pfree_q    <= pfree_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_v_q;
  assign m_res_o   = out_q;
  assign m_last_o  = out_last_q;

  a_bcast_kept: assert property (@(posedge clk_i) disable iff (!rst_ni) cvalid_q[0])
    else $error("broadcast cache entry lost");
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> hold_v_q)
    else $error("finishing without a held result");
  a_early_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && state_q == S_PCMP) |-> cmd_q.kind == K_LEARN)
    else $error("early result outside a learn");
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> !pvalid_q[pfree_q])
    else $error("claiming a busy pending slot");

endmodule

FILE: hw/rtl/arp_cache_responder_core.sv
// arp_cache_responder_core: top level of the ARP cache and responder.
// Instantiates acr_front, acr_queue and acr_back; uses acr_pkg.
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid_i/tready_o      | tdata packet fields, tuser operation
//  m_axis    | out | m_axis_tvalid_o/tready_i      | tdata mac/ip/slot/flags, tuser status, tlast
//  cfg       | in  | cfg_valid_i/cfg_ready_o       | cfg_index_i, cfg_data_i
//
// A packet that needs no cache work goes from idle straight to the finish state; a
// lookup or a learning reply scans the cache entry by entry, a read state and then
// a compare state per entry, and then the pending slots in the same way, as set by
// the single-port scan of the cache and pending stores.
// Reset leaves only the broadcast entry valid; no clearing pass is needed.
// The front keeps accepting into a two-entry queue while the back end stalls, until the queue is full.
`timescale 1ns / 1ps
module arp_cache_responder_core import acr_pkg::*; #(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned PENDING_SLOTS = PENDING_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [MAC_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // arp_opcode, hw type, proto type, hw_addr_len, proto_addr_len,
  // packet_length, sender_mac, sender_ip, target_mac, target_ip
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,   // operation
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // result_mac, result_ip, slot_index, send_request, cache_full, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [3:0]            m_axis_tuser_o,   // status
  output logic                  m_axis_tlast_o
);

  logic push, q_ready, q_valid, pop;
  cmd_t push_cmd, q_cmd;
  res_t res;

  assign cfg_ready_o = 1'b1;

  acr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_op_i      (s_axis_tuser_i),
    .s_data_i    (s_axis_tdata_i),
    .s_ready_o   (s_axis_tready_o),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .q_ready_i   (q_ready)
  );

  acr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  acr_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PENDING_SLOTS (PENDING_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_res_o   (res),
    .m_last_o  (m_axis_tlast_o),
    .m_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'b0, res.full, res.req, res.slot, res.ip, res.mac};
  assign m_axis_tuser_o = res.status;

endmodule
